@@ src/assert_macros.svh @@
// Assertion macros for the command latency monitor sources.
// Depends on nothing; included by command_latency_monitor.sv for its concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication within the same clock edge, disabled while reset is asserted.
`define CLM_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Implication that checks the consequent on the following clock edge.
`define CLM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ src/clm_pkg.sv @@
// Shared types and constants of the command latency monitor.
// No dependencies; used by the interfaces, the observation unit and the top level.
package clm_pkg;

	typedef logic [1:0]  req_type_t;
	typedef logic [15:0] seq_t;
	typedef logic [63:0] time_t;
	typedef logic [31:0] count_t;

	// Event kinds carried in req_type.
	localparam req_type_t REQ_TRANSMIT = 2'd0;
	localparam req_type_t REQ_START    = 2'd1;
	localparam req_type_t REQ_OBSERVE  = 2'd2;
	localparam req_type_t REQ_TIMEOUT  = 2'd3;

	localparam count_t LATENCY_MAX = '1;

	// The one command that is being followed.
	typedef struct packed {
		seq_t  seq;
		time_t start_time;
		logic  active;
		logic  ack_seen;
		logic  apply_seen;
	} track_t;

	// What an observation would record against the tracked command.
	typedef struct packed {
		logic   ack_hit;
		logic   apply_hit;
		count_t latency;
	} obs_t;

endpackage

@@ src/clm_if.sv @@
// Valid/ready channel interfaces of the command latency monitor.
// Depends on clm_pkg for the payload types.
interface clm_req_if;
	import clm_pkg::*;

	logic      valid;
	logic      ready;
	req_type_t req_type;
	time_t     time_us;
	seq_t      command_sequence;
	seq_t      local_ack_sequence;
	seq_t      forwarded_peer_sequence;
	seq_t      peer_ack_sequence;

	modport source (
		output valid, req_type, time_us, command_sequence,
		output local_ack_sequence, forwarded_peer_sequence, peer_ack_sequence,
		input  ready
	);
	modport sink (
		input  valid, req_type, time_us, command_sequence,
		input  local_ack_sequence, forwarded_peer_sequence, peer_ack_sequence,
		output ready
	);
endinterface

interface clm_stat_if;
	import clm_pkg::*;

	logic   valid;
	logic   ready;
	count_t frames_sent;
	count_t commands_started;
	count_t commands_acked;
	count_t commands_applied;
	count_t timeout_count;
	count_t last_ack_latency;
	count_t max_ack_latency;
	count_t last_apply_latency;
	count_t max_apply_latency;
	time_t  transmit_span_us;

	modport source (
		output valid, frames_sent, commands_started, commands_acked, commands_applied,
		output timeout_count, last_ack_latency, max_ack_latency, last_apply_latency,
		output max_apply_latency, transmit_span_us,
		input  ready
	);
	modport sink (
		input  valid, frames_sent, commands_started, commands_acked, commands_applied,
		input  timeout_count, last_ack_latency, max_ack_latency, last_apply_latency,
		input  max_apply_latency, transmit_span_us,
		output ready
	);
endinterface

@@ src/clm_observe.sv @@
// Observation check: elapsed time since the tracked start, saturated to 32 bits,
// and whether the acknowledge and apply conditions are met. Depends on clm_pkg.
module clm_observe (
	input  clm_pkg::track_t track,
	input  clm_pkg::seq_t   loc_seq,
	input  clm_pkg::seq_t   fwd_seq,
	input  clm_pkg::seq_t   peer_seq,
	input  clm_pkg::time_t  now,
	output clm_pkg::obs_t   obs
);
	import clm_pkg::*;

	logic [64:0] diff;
	logic        usable;
	logic        loc_match;
	logic        all_match;

	// The top bit of the widened difference is the borrow: time before start.
	assign diff   = {1'b0, now} - {1'b0, track.start_time};
	assign usable = track.active && !diff[64];

	assign loc_match = (loc_seq == track.seq);
	assign all_match = loc_match && (fwd_seq == track.seq) && (peer_seq == track.seq);

	assign obs.latency   = (|diff[63:32]) ? LATENCY_MAX : diff[31:0];
	assign obs.ack_hit   = usable && !track.ack_seen && loc_match;
	assign obs.apply_hit = usable && !track.apply_seen && all_match;

endmodule

@@ src/command_latency_monitor.sv @@
// Command latency monitor top level: input register, event update, result register.
// Depends on clm_pkg, clm_if (clm_req_if, clm_stat_if), clm_observe and assert_macros.svh.
`include "assert_macros.svh"

// Each request is one link event (transmission, command start, observation or
// timeout) stamped with a microsecond time. The monitor follows one command at a
// time: a start with a sequence different from the one tracked (or any start when
// nothing is tracked) arms it, and later observations record its acknowledge
// latency when the locally accepted sequence matches, and its apply latency when
// the local, forwarded and peer sequences all match, each once per command.
// Latencies saturate at 4294967295 us and the counters wrap at 32 bits. Every
// request produces exactly one statistics snapshot, taken after the event is
// applied, that includes the span between the first and last transmission times
// (zero until more than one frame was sent with a later time). The rate is one
// request per clock cycle while the consumer takes every snapshot; a request's
// snapshot passes through the input register and then the result register. The
// rate rests on the single update step on the tracking state, which the state
// registers take as the request leaves the input register, so that the next
// request sees its outcome. While the consumer stalls, one snapshot waits in the
// result register and one request in the input register; the input side stops
// only when both are full.
module command_latency_monitor (
	input  logic             clk,
	input  logic             arst_n,
	clm_req_if.sink          req,
	clm_stat_if.source       stat
);
	import clm_pkg::*;

	// Input register.
	logic      valid_s1;
	req_type_t req_type_s1;
	time_t     time_s1;
	seq_t      cseq_s1;
	seq_t      loc_s1;
	seq_t      fwd_s1;
	seq_t      peer_s1;

	// Result register.
	logic   valid_s2;
	count_t sent_s2;
	count_t started_s2;
	count_t acked_s2;
	count_t applied_s2;
	count_t timeouts_s2;
	count_t ack_last_s2;
	count_t ack_peak_s2;
	count_t apply_last_s2;
	count_t apply_peak_s2;
	time_t  span_s2;

	// Monitor state.
	count_t sent_q;
	count_t started_q;
	count_t acked_q;
	count_t applied_q;
	count_t timeouts_q;
	count_t ack_last_q;
	count_t ack_peak_q;
	count_t apply_last_q;
	count_t apply_peak_q;
	time_t  first_send_q;
	time_t  last_send_q;
	track_t track_q;

	// Next state, which is also the snapshot of the request in the input register.
	count_t sent_d;
	count_t started_d;
	count_t acked_d;
	count_t applied_d;
	count_t timeouts_d;
	count_t ack_last_d;
	count_t ack_peak_d;
	count_t apply_last_d;
	count_t apply_peak_d;
	time_t  first_send_d;
	time_t  last_send_d;
	track_t track_d;
	time_t  span_d;

	logic        adv_s1;
	logic        adv_s2;
	logic        req_fire;
	logic [64:0] span_diff;
	obs_t        obs;

	// The result register takes a new snapshot when it is empty or being read out;
	// the input register moves on whenever its request can enter the result register.
	assign adv_s2    = !valid_s2 || stat.ready;
	assign adv_s1    = valid_s1 && adv_s2;
	assign req.ready = !valid_s1 || adv_s2;
	assign req_fire  = req.valid && req.ready;

	// The event kind is reset so that the update decode always sees a defined code.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			req_type_s1 <= REQ_TRANSMIT;
		end else begin
			valid_s1 <= req_fire || (valid_s1 && !adv_s1);
			if (req_fire) begin
				req_type_s1 <= req.req_type;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_fire) begin
			time_s1     <= req.time_us;
			cseq_s1     <= req.command_sequence;
			loc_s1      <= req.local_ack_sequence;
			fwd_s1      <= req.forwarded_peer_sequence;
			peer_s1     <= req.peer_ack_sequence;
		end
	end

	clm_observe u_observe (
		.track    (track_q),
		.loc_seq  (loc_s1),
		.fwd_seq  (fwd_s1),
		.peer_seq (peer_s1),
		.now      (time_s1),
		.obs      (obs)
	);

	// Apply the event to the state. Only the fields touched by the event change.
	always_comb begin
		sent_d       = sent_q;
		started_d    = started_q;
		acked_d      = acked_q;
		applied_d    = applied_q;
		timeouts_d   = timeouts_q;
		ack_last_d   = ack_last_q;
		ack_peak_d   = ack_peak_q;
		apply_last_d = apply_last_q;
		apply_peak_d = apply_peak_q;
		first_send_d = first_send_q;
		last_send_d  = last_send_q;
		track_d      = track_q;

		unique case (req_type_s1)
			REQ_TRANSMIT: begin
				// The first frame after reset, or after the counter wraps, opens the span.
				if (sent_q == '0) begin
					first_send_d = time_s1;
				end
				last_send_d = time_s1;
				sent_d      = sent_q + 1'b1;
			end
			REQ_START: begin
				// Restating the command already tracked does not rearm it.
				if (!(track_q.active && (cseq_s1 == track_q.seq))) begin
					track_d.seq        = cseq_s1;
					track_d.start_time = time_s1;
					track_d.active     = 1'b1;
					track_d.ack_seen   = 1'b0;
					track_d.apply_seen = 1'b0;
					started_d          = started_q + 1'b1;
				end
			end
			REQ_OBSERVE: begin
				// Both the acknowledge and the apply may land on the same observation.
				if (obs.ack_hit) begin
					track_d.ack_seen = 1'b1;
					acked_d          = acked_q + 1'b1;
					ack_last_d       = obs.latency;
					if (obs.latency > ack_peak_q) begin
						ack_peak_d = obs.latency;
					end
				end
				if (obs.apply_hit) begin
					track_d.apply_seen = 1'b1;
					applied_d          = applied_q + 1'b1;
					apply_last_d       = obs.latency;
					if (obs.latency > apply_peak_q) begin
						apply_peak_d = obs.latency;
					end
				end
			end
			REQ_TIMEOUT: begin
				timeouts_d = timeouts_q + 1'b1;
			end
		endcase
	end

	// The span counts only with more than one frame and a strictly later last time;
	// a clear borrow and a nonzero difference together mean strictly later.
	assign span_diff = {1'b0, last_send_d} - {1'b0, first_send_d};
	assign span_d    = ((sent_d > count_t'(1)) && !span_diff[64] && (|span_diff[63:0]))
		? span_diff[63:0] : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sent_q       <= '0;
			started_q    <= '0;
			acked_q      <= '0;
			applied_q    <= '0;
			timeouts_q   <= '0;
			ack_last_q   <= '0;
			ack_peak_q   <= '0;
			apply_last_q <= '0;
			apply_peak_q <= '0;
			first_send_q <= '0;
			last_send_q  <= '0;
			track_q      <= '0;
		end else if (adv_s1) begin
			sent_q       <= sent_d;
			started_q    <= started_d;
			acked_q      <= acked_d;
			applied_q    <= applied_d;
			timeouts_q   <= timeouts_d;
			ack_last_q   <= ack_last_d;
			ack_peak_q   <= ack_peak_d;
			apply_last_q <= apply_last_d;
			apply_peak_q <= apply_peak_d;
			first_send_q <= first_send_d;
			last_send_q  <= last_send_d;
			track_q      <= track_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= adv_s1 || (valid_s2 && !stat.ready);
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			sent_s2       <= sent_d;
			started_s2    <= started_d;
			acked_s2      <= acked_d;
			applied_s2    <= applied_d;
			timeouts_s2   <= timeouts_d;
			ack_last_s2   <= ack_last_d;
			ack_peak_s2   <= ack_peak_d;
			apply_last_s2 <= apply_last_d;
			apply_peak_s2 <= apply_peak_d;
			span_s2       <= span_d;
		end
	end

	assign stat.valid              = valid_s2;
	assign stat.frames_sent        = sent_s2;
	assign stat.commands_started   = started_s2;
	assign stat.commands_acked     = acked_s2;
	assign stat.commands_applied   = applied_s2;
	assign stat.timeout_count      = timeouts_s2;
	assign stat.last_ack_latency   = ack_last_s2;
	assign stat.max_ack_latency    = ack_peak_s2;
	assign stat.last_apply_latency = apply_last_s2;
	assign stat.max_apply_latency  = apply_peak_s2;
	assign stat.transmit_span_us   = span_s2;

	// An apply is only ever recorded together with or after the acknowledge.
	`CLM_ASSERT_SAME(a_apply_after_ack, clk, arst_n, track_q.apply_seen, track_q.ack_seen, "apply recorded without acknowledge")
	// The peaks never fall below the most recent latencies.
	`CLM_ASSERT_SAME(a_ack_peak, clk, arst_n, 1'b1, ack_peak_q >= ack_last_q, "acknowledge peak below last")
	`CLM_ASSERT_SAME(a_apply_peak, clk, arst_n, 1'b1, apply_peak_q >= apply_last_q, "apply peak below last")
	// Acknowledge count moves only on an observation that leaves the input register.
	`CLM_ASSERT_NEXT(a_ack_count_hold, clk, arst_n, !(adv_s1 && (req_type_s1 == REQ_OBSERVE)), acked_q == $past(acked_q), "acknowledge count changed without observation")

endmodule
